// ----- hdl/run_group_coordinate_mean_core_macros.svh -----
// Assertion macros shared by the checker of the run-group mean core.
`ifndef RUN_GROUP_COORDINATE_MEAN_CORE_MACROS_SVH
`define RUN_GROUP_COORDINATE_MEAN_CORE_MACROS_SVH

// Property checked only while the block is out of reset.
`define RGCM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property that must also hold across reset.
`define RGCM_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hdl/rgcm_pkg.sv -----
// Types and constants shared by the run-group mean core modules.
package rgcm_pkg;

    localparam int unsigned COORD_W    = 32;
    localparam int unsigned KEY_W      = 32;
    // Wide enough for the sum of 63 full-range coordinates.
    localparam int unsigned SUM_W      = 38;
    localparam int unsigned CNT_W      = 6;
    localparam int unsigned LANES      = 3;
    localparam int unsigned FIFO_DEPTH = 2;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [SUM_W-1:0]   t_sum;
    typedef logic [CNT_W-1:0]          t_count;
    typedef logic [KEY_W-1:0]          t_key;

    typedef struct packed {
        t_key   cell_key;
        t_coord center_x;
        t_coord center_y;
        t_coord center_z;
        logic   end_of_data;
    } t_in_item;

    typedef struct packed {
        t_coord mean_x;
        t_coord mean_y;
        t_coord mean_z;
        t_key   group_key;
        logic   last_of_burst;
    } t_out_item;

    // A closed run handed from the front to the back.
    typedef struct packed {
        t_sum   sum_x;
        t_sum   sum_y;
        t_sum   sum_z;
        t_count count;
        t_key   key;
        logic   last;
    } t_close_cmd;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_DIV,
        BACK_EMIT
    } t_back_state;

endpackage

// ----- hdl/rgcm_front.sv -----
// Front end: accepts cells, accumulates the open run and issues close requests.
module rgcm_front
    import rgcm_pkg::*;
#(
    parameter int unsigned MAX_RUN = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  t_in_item   i_item,
    output logic       o_cmd_wr,
    output t_close_cmd o_cmd,
    input  logic       i_cmd_full
);

    t_in_item r_item;
    logic     r_item_vld;
    t_key     r_run_key;
    t_count   r_run_cnt;
    t_sum     r_sum [LANES];

    t_sum     item_c   [LANES];
    t_sum     sum_new  [LANES];
    t_count   cnt_new;
    logic     key_diff;
    logic     close_new;
    logic     advance;

    assign item_c[0] = t_sum'(r_item.center_x);
    assign item_c[1] = t_sum'(r_item.center_y);
    assign item_c[2] = t_sum'(r_item.center_z);

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            sum_new[i] = r_sum[i] + item_c[i];
        end
    end

    assign cnt_new   = r_run_cnt + 1'b1;
    assign key_diff  = (r_run_cnt != '0) && (r_item.cell_key != r_run_key);
    assign close_new = (cnt_new == t_count'(MAX_RUN)) || r_item.end_of_data;
    assign advance   = r_item_vld && (!(key_diff || close_new) || !i_cmd_full);
    assign o_cmd_wr  = r_item_vld && (key_diff || close_new) && !i_cmd_full;
    assign full      = r_item_vld;

    // A key change first closes the old run; the cell is then taken against an empty run on
    // the following cycle, unless its own close request then finds the queue full.
    always_comb begin
        if (key_diff) begin
            o_cmd.sum_x = r_sum[0];
            o_cmd.sum_y = r_sum[1];
            o_cmd.sum_z = r_sum[2];
            o_cmd.count = r_run_cnt;
            o_cmd.key   = r_run_key;
            o_cmd.last  = !r_item.end_of_data;
        end else begin
            o_cmd.sum_x = sum_new[0];
            o_cmd.sum_y = sum_new[1];
            o_cmd.sum_z = sum_new[2];
            o_cmd.count = cnt_new;
            o_cmd.key   = r_item.cell_key;
            o_cmd.last  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_vld <= 1'b0;
            r_run_cnt  <= '0;
            r_run_key  <= '0;
            for (int i = 0; i < LANES; i++) begin
                r_sum[i] <= '0;
            end
        end else begin
            if (push && !r_item_vld) begin
                r_item_vld <= 1'b1;
            end else if (advance) begin
                if (key_diff) begin
                    r_run_cnt <= '0;
                    for (int i = 0; i < LANES; i++) begin
                        r_sum[i] <= '0;
                    end
                end else begin
                    r_item_vld <= 1'b0;
                    r_run_key  <= r_item.cell_key;
                    if (close_new) begin
                        r_run_cnt <= '0;
                        for (int i = 0; i < LANES; i++) begin
                            r_sum[i] <= '0;
                        end
                    end else begin
                        r_run_cnt <= cnt_new;
                        for (int i = 0; i < LANES; i++) begin
                            r_sum[i] <= sum_new[i];
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push && !r_item_vld) begin
            r_item <= i_item;
        end
    end

endmodule

// ----- hdl/rgcm_cmd_fifo.sv -----
// Short queue of close requests between the front and the back.
module rgcm_cmd_fifo
    import rgcm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_wr,
    input  t_close_cmd i_data,
    output logic       o_full,
    input  logic       i_rd,
    output t_close_cmd o_data,
    output logic       o_empty
);

    localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned LVL_W = $clog2(FIFO_DEPTH + 1);

    t_close_cmd       r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [LVL_W-1:0] r_level;
    logic             do_wr;
    logic             do_rd;

    assign o_full  = (r_level == LVL_W'(FIFO_DEPTH));
    assign o_empty = (r_level == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_level <= r_level + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- hdl/rgcm_back.sv -----
// Back end: divides the three run sums by the cell count and emits the copies.
module rgcm_back
    import rgcm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_close_cmd i_cmd,
    input  logic       i_cmd_empty,
    output logic       o_cmd_pop,
    output t_out_item  o_result,
    output logic       empty,
    input  logic       pop
);

    localparam int unsigned STEP_W = $clog2(SUM_W);

    typedef struct packed {
        t_count           rem;
        logic [SUM_W-1:0] quo;
    } t_div_lane;

    // One restoring step: the quotient register shifts the dividend out
    // at the top while quotient bits enter at the bottom.
    function automatic t_div_lane div_step(t_div_lane cur, t_count divisor);
        logic [CNT_W:0] trial;
        logic           qbit;
        t_div_lane      nxt;
        trial = {cur.rem, cur.quo[SUM_W-1]};
        qbit  = (trial >= {1'b0, divisor});
        if (qbit) begin
            nxt.rem = CNT_W'(trial - {1'b0, divisor});
        end else begin
            nxt.rem = trial[CNT_W-1:0];
        end
        nxt.quo = {cur.quo[SUM_W-2:0], qbit};
        return nxt;
    endfunction

    t_back_state      r_state;
    t_back_state      n_state;
    t_div_lane        r_lane [LANES];
    logic             r_neg  [LANES];
    t_count           r_count;
    t_key             r_key;
    logic             r_last;
    logic [STEP_W-1:0] r_step;
    t_count           r_emit_cnt;
    t_out_item        r_out;
    logic             r_out_vld;

    t_sum             cmd_sum [LANES];
    logic [SUM_W-1:0] quo_s   [LANES];
    logic             div_run;
    logic             emit_load;
    logic             emit_final;
    t_out_item        result;

    assign cmd_sum[0] = i_cmd.sum_x;
    assign cmd_sum[1] = i_cmd.sum_y;
    assign cmd_sum[2] = i_cmd.sum_z;

    assign emit_final = (r_emit_cnt == t_count'(r_count - 1'b1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BACK_IDLE: begin
                if (!i_cmd_empty) begin
                    n_state = BACK_DIV;
                end
            end
            BACK_DIV: begin
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    n_state = BACK_EMIT;
                end
            end
            BACK_EMIT: begin
                if (emit_load && emit_final) begin
                    n_state = BACK_IDLE;
                end
            end
            default: n_state = BACK_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop = 1'b0;
        div_run   = 1'b0;
        emit_load = 1'b0;
        unique case (r_state)
            BACK_IDLE: o_cmd_pop = !i_cmd_empty;
            BACK_DIV:  div_run   = 1'b1;
            BACK_EMIT: emit_load = !r_out_vld || pop;
            default: begin
                o_cmd_pop = 1'b0;
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            quo_s[i] = r_neg[i] ? (~r_lane[i].quo + 1'b1) : r_lane[i].quo;
        end
        result.mean_x        = t_coord'(quo_s[0][COORD_W-1:0]);
        result.mean_y        = t_coord'(quo_s[1][COORD_W-1:0]);
        result.mean_z        = t_coord'(quo_s[2][COORD_W-1:0]);
        result.group_key     = r_key;
        result.last_of_burst = r_last && emit_final;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BACK_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit_load) begin
                r_out_vld <= 1'b1;
            end else if (pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            for (int i = 0; i < LANES; i++) begin
                r_neg[i]      <= cmd_sum[i][SUM_W-1];
                r_lane[i].quo <= cmd_sum[i][SUM_W-1] ? (~cmd_sum[i] + 1'b1) : cmd_sum[i];
                r_lane[i].rem <= '0;
            end
            r_count    <= i_cmd.count;
            r_key      <= i_cmd.key;
            r_last     <= i_cmd.last;
            r_step     <= '0;
            r_emit_cnt <= '0;
        end
        if (div_run) begin
            for (int i = 0; i < LANES; i++) begin
                r_lane[i] <= div_step(r_lane[i], r_count);
            end
            r_step <= r_step + 1'b1;
        end
        if (emit_load) begin
            r_out      <= result;
            r_emit_cnt <= r_emit_cnt + 1'b1;
        end
    end

    assign o_result = r_out;
    assign empty    = !r_out_vld;

endmodule

// ----- hdl/run_group_coordinate_mean_core.sv -----
// With the back end idle, a run's first result follows the cell that closes it: its close
// request is queued, the back end divides the three run sums in parallel bit-serial lanes,
// then emits one result per cycle while the result port is not stalled; it takes the next
// request only after a run's last result. The front end holds one cell at a time.
// Reset is synchronous and active low; it empties the queue and the output register
// and leaves no open run, and no clearing pass follows.
module run_group_coordinate_mean_core
    import rgcm_pkg::*;
#(
    parameter int unsigned MAX_RUN = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_result
);

    logic       cmd_wr;
    logic       cmd_full;
    logic       cmd_pop;
    logic       cmd_empty;
    t_close_cmd cmd_in;
    t_close_cmd cmd_out;

    rgcm_front #(
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .o_cmd_wr   (cmd_wr),
        .o_cmd      (cmd_in),
        .i_cmd_full (cmd_full)
    );

    rgcm_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_wr),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_rd    (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty)
    );

    rgcm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_out),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_result    (o_result),
        .empty       (empty),
        .pop         (pop)
    );

endmodule

// ----- hdl/rgcm_checker.sv -----
// Port-level checker for the run-group mean core, bound to the top level.
`include "run_group_coordinate_mean_core_macros.svh"

module rgcm_checker
    import rgcm_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      push,
    input logic      full,
    input logic      empty,
    input logic      pop,
    input t_out_item o_result
);

    `RGCM_ASSERT_RST(a_rst_empty, !i_rst_n |=> empty, "result queue not empty after reset")
    `RGCM_ASSERT_RST(a_rst_full, !i_rst_n |=> !full, "input side full after reset")
    // The front holds one cell at a time, so a taken request always blocks the next cycle.
    `RGCM_ASSERT(a_push_blocks, push && !full |=> full, "input not blocked after a request")
    `RGCM_ASSERT(a_out_hold, !empty && !pop |=> !empty && $stable(o_result), "result lost")

endmodule

bind run_group_coordinate_mean_core rgcm_checker u_rgcm_checker (.*);

// ----- dv/tb_run_group_coordinate_mean_core.sv -----
// Self-checking testbench for the run-group coordinate mean core.
module tb_run_group_coordinate_mean_core;
    import rgcm_pkg::*;

    localparam int unsigned RUN_LIMIT    = 32;
    localparam int unsigned PHASE_ITEMS  = 30;
    localparam int unsigned DRAIN_CYCLES = 120;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned REPORT_LIMIT = 10;

    localparam t_coord C_MAX = t_coord'(32'h7fff_ffff);
    localparam t_coord C_MIN = t_coord'(32'h8000_0000);

    // Predicts the run means and holds the results still owed by the block.
    class run_mean_scoreboard;
        int unsigned run_limit;
        t_key        open_key;
        int unsigned open_count;
        longint      sum_x;
        longint      sum_y;
        longint      sum_z;
        t_out_item   burst[$];
        t_out_item   mean_queue[$];
        int unsigned requests;
        int unsigned results;
        int unsigned runs_closed;
        int unsigned full_runs;
        int unsigned mismatches;

        function new(int unsigned limit);
            run_limit   = limit;
            open_key    = '0;
            open_count  = 0;
            sum_x       = 0;
            sum_y       = 0;
            sum_z       = 0;
            requests    = 0;
            results     = 0;
            runs_closed = 0;
            full_runs   = 0;
            mismatches  = 0;
        endfunction

        // Every cell of the closing run gets a copy of the run mean.
        function void close_run();
            t_out_item r;
            r.mean_x        = t_coord'(sum_x / longint'(open_count));
            r.mean_y        = t_coord'(sum_y / longint'(open_count));
            r.mean_z        = t_coord'(sum_z / longint'(open_count));
            r.group_key     = open_key;
            r.last_of_burst = 1'b0;
            repeat (open_count) burst.push_back(r);
            runs_closed++;
            if (open_count == run_limit) full_runs++;
            open_count = 0;
            sum_x      = 0;
            sum_y      = 0;
            sum_z      = 0;
        endfunction

        function void note_request(t_in_item req);
            t_out_item tail;
            requests++;
            burst.delete();
            if (open_count != 0 && req.cell_key != open_key) close_run();
            if (open_count == 0) open_key = req.cell_key;
            sum_x += longint'($signed(req.center_x));
            sum_y += longint'($signed(req.center_y));
            sum_z += longint'($signed(req.center_z));
            open_count++;
            if (open_count >= run_limit || req.end_of_data) close_run();
            if (burst.size() != 0) begin
                tail = burst.pop_back();
                tail.last_of_burst = 1'b1;
                burst.push_back(tail);
                foreach (burst[i]) mean_queue.push_back(burst[i]);
            end
        endfunction

        function void check_mean(t_out_item got);
            t_out_item want;
            results++;
            if (mean_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("ERROR: unexpected result %0d: x=%0d y=%0d z=%0d key=%h last=%b",
                             results, got.mean_x, got.mean_y, got.mean_z, got.group_key,
                             got.last_of_burst);
            end else begin
                want = mean_queue.pop_front();
                if (got.mean_x !== want.mean_x || got.mean_y !== want.mean_y ||
                    got.mean_z !== want.mean_z || got.group_key !== want.group_key ||
                    got.last_of_burst !== want.last_of_burst) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("ERROR: result %0d expected x=%0d y=%0d z=%0d key=%h last=%b",
                                 results, want.mean_x, want.mean_y, want.mean_z,
                                 want.group_key, want.last_of_burst);
                        $display("       got                x=%0d y=%0d z=%0d key=%h last=%b",
                                 got.mean_x, got.mean_y, got.mean_z, got.group_key,
                                 got.last_of_burst);
                    end
                end
            end
        endfunction
    endclass

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    logic      pop     = 1'b0;
    t_in_item  i_item  = '0;
    logic      full;
    logic      empty;
    t_out_item o_result;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned cycles         = 0;

    run_mean_scoreboard sb;

    run_group_coordinate_mean_core #(
        .MAX_RUN(RUN_LIMIT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_result(o_result)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Both handshakes are sampled here, so the scoreboard sees the pre-edge values.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && push && !full) sb.note_request(i_item);
        if (i_rst_n && pop && !empty) sb.check_mean(o_result);
        pop <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Push stays high after acceptance; the next request or a pause decides its value.
    task automatic send_request(input t_key key, input t_coord x, y, z, input logic eod);
        t_in_item req;
        req.cell_key    = key;
        req.center_x    = x;
        req.center_y    = y;
        req.center_z    = z;
        req.end_of_data = eod;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= req;
        do @(posedge i_clk); while (full);
    endtask

    // One edge passes first so that the last accepted request is already predicted.
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (sb.mean_queue.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_coord rand_coord();
        case ($urandom_range(7))
            0:       return C_MAX;
            1:       return C_MIN;
            2:       return '0;
            3:       return t_coord'(-1);
            default: return t_coord'($urandom);
        endcase
    endfunction

    function automatic t_key pick_key(input t_key prev);
        case ($urandom_range(7))
            0:       return prev;
            1:       return '0;
            2:       return '1;
            default: return t_key'($urandom);
        endcase
    endfunction

    // A well-formed run; now and then a stray flush lands in the middle of it.
    task automatic send_run(input t_key key, input int unsigned len, input logic eod_last);
        int unsigned mode;
        logic        eod;
        mode = $urandom_range(5);
        for (int unsigned n = 0; n < len; n++) begin
            eod = (n == len - 1) ? eod_last : ($urandom_range(39) == 0);
            case (mode)
                0:       send_request(key, C_MAX, C_MAX, C_MAX, eod);
                1:       send_request(key, C_MIN, C_MIN, C_MIN, eod);
                default: send_request(key, rand_coord(), rand_coord(), rand_coord(), eod);
            endcase
        end
    endtask

    task automatic random_phase(input int unsigned count);
        int unsigned sent = 0;
        int unsigned len;
        t_key        key  = '0;
        while (sent < count) begin
            if ($urandom_range(9) == 0) begin
                // Noise: unrelated keys with frequent flushes.
                len = $urandom_range(4, 1);
                repeat (len)
                    send_request(t_key'($urandom), rand_coord(), rand_coord(), rand_coord(),
                                 $urandom_range(2) == 0);
            end else begin
                key = pick_key(key);
                len = ($urandom_range(7) == 0) ? $urandom_range(RUN_LIMIT + 4, RUN_LIMIT - 2)
                                               : $urandom_range(5, 1);
                send_run(key, len, $urandom_range(5) == 0);
            end
            sent += len;
        end
    endtask

    initial begin
        sb = new(RUN_LIMIT);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single-cell runs at the extremes come back unchanged.
        send_request('0, C_MAX, C_MAX, C_MAX, 1'b1);
        send_request('1, C_MIN, C_MIN, C_MIN, 1'b1);
        // Mixed signs check truncation toward zero; the flush arrives with a new key.
        send_request(t_key'(5), t_coord'(-1), t_coord'(-7), t_coord'(7), 1'b0);
        send_request(t_key'(5), t_coord'(-1), t_coord'(0), t_coord'(0), 1'b0);
        send_request(t_key'(5), t_coord'(1), t_coord'(0), t_coord'(1), 1'b0);
        send_request(t_key'(6), t_coord'(3), t_coord'(-3), C_MIN, 1'b1);
        // Extreme sums, closed by a key change and then by a flush.
        repeat (4) send_request(t_key'(7), C_MAX, C_MIN, t_coord'(5), 1'b0);
        send_request(t_key'(8), C_MIN, C_MAX, t_coord'(-5), 1'b0);
        send_request(t_key'(8), C_MIN, C_MAX, t_coord'(-6), 1'b0);
        send_request(t_key'(8), C_MIN, C_MAX, t_coord'(-6), 1'b0);
        send_request(t_key'(8), C_MIN, C_MAX, t_coord'(-6), 1'b1);
        // The same key after a flush opens a fresh run.
        send_request(t_key'(8), t_coord'(1), t_coord'(-1), t_coord'(0), 1'b1);
        send_request(t_key'(32'haaaa_aaaa), t_coord'(32'h5555_5555), t_coord'(32'haaaa_aaaa),
                     t_coord'(32'h5555_5555), 1'b0);
        send_request(t_key'(32'h5555_5555), t_coord'(32'haaaa_aaaa), t_coord'(32'h5555_5555),
                     t_coord'(32'haaaa_aaaa), 1'b1);
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            random_phase(PHASE_ITEMS);
            wait_drained();
        end

        // Flush whatever run is still open.
        send_request(t_key'($urandom), rand_coord(), rand_coord(), rand_coord(), 1'b1);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests in %0d runs (%0d full-length), %0d results checked.",
                 sb.requests, sb.runs_closed, sb.full_runs, sb.results);
        $display("Mismatches: %0d, results still owed: %0d.", sb.mismatches,
                 sb.mean_queue.size());
        if (sb.mismatches == 0 && sb.mean_queue.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
